[design/smat_pkg.sv]
// Shared types and codes for the sorted MAC alias table.
package smat_pkg;

  // Request operation codes
  typedef enum logic [2:0] {
    ACT_CLEAR     = 3'd0,
    ACT_ADD       = 3'd1,
    ACT_FIND_MAC  = 3'd2,
    ACT_FIND_NAME = 3'd3,
    ACT_REM_IDX   = 3'd4,
    ACT_REM_MAC   = 3'd5,
    ACT_REM_NAME  = 3'd6,
    ACT_READ_IDX  = 3'd7
  } action_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_FULL     = 3'd2,
    ST_DUP      = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_APPLY
  } state_t;

  localparam int MAC_W  = 48;
  localparam int NAME_W = 64;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic    match;  // latch per-cell select and duplicate flags
    logic    scan;   // shift the result chain toward cell 0
    logic    ins;    // open a slot at pos and write the request entry
    logic    rem;    // close the gap at pos
    action_t op;
  } cell_ctl_t;

endpackage

[design/smat_cell.sv]
// One table slot: stored entry, local compares and one stage of the result chain.
module smat_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int CW  = 5
) (
  input  logic                       clk,
  input  smat_pkg::cell_ctl_t        ctl,
  input  logic [CW-1:0]              count,
  input  logic [IW-1:0]              pos,
  input  logic [smat_pkg::MAC_W-1:0] q_key,
  input  logic [smat_pkg::NAME_W-1:0] q_name,
  input  logic [IW-1:0]              q_idx,
  // neighbor below (index - 1)
  input  logic [smat_pkg::MAC_W-1:0] prev_key,
  input  logic [smat_pkg::NAME_W-1:0] prev_name,
  input  logic                       prev_gt,
  // neighbor above (index + 1)
  input  logic [smat_pkg::MAC_W-1:0] next_key,
  input  logic [smat_pkg::NAME_W-1:0] next_name,
  output logic [smat_pkg::MAC_W-1:0] key_o,
  output logic [smat_pkg::NAME_W-1:0] name_o,
  output logic                       gt_o,
  // result chain, entering from the cell above
  input  logic                       pin_vld,
  input  logic [IW-1:0]              pin_idx,
  input  logic [smat_pkg::MAC_W-1:0] pin_key,
  input  logic [smat_pkg::NAME_W-1:0] pin_name,
  input  logic                       pin_dup,
  output logic                       pout_vld,
  output logic [IW-1:0]              pout_idx,
  output logic [smat_pkg::MAC_W-1:0] pout_key,
  output logic [smat_pkg::NAME_W-1:0] pout_name,
  output logic                       pout_dup
);

  localparam logic [CW-1:0] MY_CNT = CW'(IDX);
  localparam logic [IW-1:0] MY_POS = IW'(IDX);

  logic [smat_pkg::MAC_W-1:0]  key_r;
  logic [smat_pkg::NAME_W-1:0] name_r;
  logic                        sel_r, sel_nxt;
  logic                        dupm_r;
  logic                        pvld_r;
  logic [IW-1:0]               pidx_r;
  logic [smat_pkg::MAC_W-1:0]  pkey_r;
  logic [smat_pkg::NAME_W-1:0] pname_r;
  logic                        pdup_r;
  logic                        valid;
  logic                        key_eq;
  logic                        name_eq;
  logic                        ins_here;

  // Local compares against the request
  assign valid    = MY_CNT < count;
  assign key_eq   = valid && (key_r == q_key);
  assign name_eq  = valid && (name_r == q_name);
  assign gt_o     = valid && (key_r > q_key);
  // Insert slot: first slot whose key is above the request, or the first free one
  assign ins_here = !prev_gt && (gt_o || (MY_CNT == count));

  assign key_o  = key_r;
  assign name_o = name_r;

  // Select for this request
  always_comb begin
    case (ctl.op)
      smat_pkg::ACT_ADD:       sel_nxt = ins_here;
      smat_pkg::ACT_FIND_MAC,
      smat_pkg::ACT_REM_MAC:   sel_nxt = key_eq;
      smat_pkg::ACT_FIND_NAME,
      smat_pkg::ACT_REM_NAME:  sel_nxt = name_eq;
      smat_pkg::ACT_REM_IDX,
      smat_pkg::ACT_READ_IDX:  sel_nxt = valid && (MY_POS == q_idx);
      default:                 sel_nxt = 1'b0;
    endcase
  end

  // Match flags and result chain
  always_ff @(posedge clk) begin
    if (ctl.match) begin
      sel_r   <= sel_nxt;
      dupm_r  <= key_eq || name_eq;
      pvld_r  <= 1'b0;
      pidx_r  <= '0;
      pkey_r  <= '0;
      pname_r <= '0;
      pdup_r  <= 1'b0;
    end else if (ctl.scan) begin
      pdup_r <= dupm_r || pin_dup;
      if (sel_r) begin
        pvld_r  <= 1'b1;
        pidx_r  <= MY_POS;
        pkey_r  <= key_r;
        pname_r <= name_r;
      end else begin
        pvld_r  <= pin_vld;
        pidx_r  <= pin_idx;
        pkey_r  <= pin_key;
        pname_r <= pin_name;
      end
    end
  end

  // Entry storage: shift up on insert, down on remove
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (MY_POS > pos) begin
        key_r  <= prev_key;
        name_r <= prev_name;
      end else if (MY_POS == pos) begin
        key_r  <= q_key;
        name_r <= q_name;
      end
    end else if (ctl.rem) begin
      if (MY_POS >= pos) begin
        key_r  <= next_key;
        name_r <= next_name;
      end
    end
  end

  assign pout_vld  = pvld_r;
  assign pout_idx  = pidx_r;
  assign pout_key  = pkey_r;
  assign pout_name = pname_r;
  assign pout_dup  = pdup_r;

endmodule

[design/sorted_mac_alias_table.sv]
// Each request steps through S_MATCH, S_SCAN and S_APPLY; the result is registered in S_APPLY.
// One request at a time: in_ready stays low until S_APPLY returns to idle; the result chain walks all cells to cell 0.
// A held result does not block the next request until that request reaches its apply step.
// Reset (rst_n low, synchronous) empties the table, clears out_valid and returns in_ready high;
// stored entries are not cleared and are never read before being written.
// Top level: request sequencer, name normalization, row of table cells.
module sorted_mac_alias_table #(
  parameter  int ENTRIES    = 16,
  parameter  int NAME_CHARS = 8,
  localparam int IW         = $clog2(ENTRIES),
  localparam int CW         = $clog2(ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_action,
  input  logic [smat_pkg::MAC_W-1:0]  in_mac_key,
  input  logic [smat_pkg::NAME_W-1:0] in_alias_name,
  input  logic [IW-1:0]               in_entry_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [IW-1:0]               out_found_index,
  output logic [smat_pkg::MAC_W-1:0]  out_mac_out,
  output logic [smat_pkg::NAME_W-1:0] out_name_out,
  output logic [CW-1:0]               out_entry_count
);

  localparam int NB = smat_pkg::NAME_W / 8;

  smat_pkg::state_t            state_r, state_nxt;
  smat_pkg::action_t           op_r;
  logic [smat_pkg::MAC_W-1:0]  mac_r;
  logic [smat_pkg::NAME_W-1:0] name_r;
  logic [smat_pkg::NAME_W-1:0] name_norm;
  logic [IW-1:0]               idx_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [IW-1:0]               scan_r, scan_nxt;
  logic                        ovld_r, ovld_nxt;
  smat_pkg::status_t           ost_r, ost_nxt;
  logic [IW-1:0]               oidx_r, oidx_nxt;
  logic [smat_pkg::MAC_W-1:0]  omac_r, omac_nxt;
  logic [smat_pkg::NAME_W-1:0] oname_r, oname_nxt;
  logic [CW-1:0]               ocnt_r, ocnt_nxt;
  logic                        do_ins, do_rem;
  logic                        accept;
  smat_pkg::cell_ctl_t         ctl;

  // Cell row wiring; chain arrays carry one extra stage tied off above the top cell
  logic [smat_pkg::MAC_W-1:0]  cell_key  [ENTRIES];
  logic [smat_pkg::NAME_W-1:0] cell_name [ENTRIES];
  logic                        cell_gt   [ENTRIES];
  logic                        p_vld     [ENTRIES+1];
  logic [IW-1:0]               p_idx     [ENTRIES+1];
  logic [smat_pkg::MAC_W-1:0]  p_key     [ENTRIES+1];
  logic [smat_pkg::NAME_W-1:0] p_name    [ENTRIES+1];
  logic                        p_dup     [ENTRIES+1];

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == smat_pkg::S_IDLE);

  // Name cut to NAME_CHARS bytes and ended at its first zero byte
  always_comb begin
    logic keep;
    keep      = 1'b1;
    name_norm = '0;
    for (int b = 0; b < NB; b++) begin
      if (b < NAME_CHARS && keep && in_alias_name[8*b +: 8] != 8'd0) begin
        name_norm[8*b +: 8] = in_alias_name[8*b +: 8];
      end else begin
        keep = 1'b0;
      end
    end
  end

  // Request registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= smat_pkg::action_t'(in_action);
      mac_r  <= in_mac_key;
      name_r <= name_norm;
      idx_r  <= in_entry_index;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smat_pkg::S_IDLE;
      count_r <= '0;
      scan_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    ost_r   <= ost_nxt;
    oidx_r  <= oidx_nxt;
    omac_r  <= omac_nxt;
    oname_r <= oname_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  // Sequencer: next state, table update and result
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    scan_nxt  = scan_r;
    ovld_nxt  = ovld_r && !out_ready;
    ost_nxt   = ost_r;
    oidx_nxt  = oidx_r;
    omac_nxt  = omac_r;
    oname_nxt = oname_r;
    ocnt_nxt  = ocnt_r;
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    case (state_r)
      smat_pkg::S_IDLE: begin
        if (accept) state_nxt = smat_pkg::S_MATCH;
      end
      smat_pkg::S_MATCH: begin
        scan_nxt  = '0;
        state_nxt = smat_pkg::S_SCAN;
      end
      smat_pkg::S_SCAN: begin
        scan_nxt = scan_r + IW'(1);
        if (scan_r == IW'(ENTRIES - 1)) state_nxt = smat_pkg::S_APPLY;
      end
      smat_pkg::S_APPLY: begin
        // wait for the previous result to leave
        if (!ovld_r || out_ready) begin
          state_nxt = smat_pkg::S_IDLE;
          ovld_nxt  = 1'b1;
          ost_nxt   = smat_pkg::ST_OK;
          oidx_nxt  = '0;
          omac_nxt  = '0;
          oname_nxt = '0;
          case (op_r)
            smat_pkg::ACT_CLEAR: begin
              count_nxt = '0;
            end
            smat_pkg::ACT_ADD: begin
              if (name_r == '0) begin
                ost_nxt = smat_pkg::ST_EMPTY;
              end else if (count_r == CW'(ENTRIES)) begin
                ost_nxt = smat_pkg::ST_FULL;
              end else if (p_dup[0]) begin
                ost_nxt = smat_pkg::ST_DUP;
              end else begin
                do_ins    = 1'b1;
                count_nxt = count_r + CW'(1);
                oidx_nxt  = p_idx[0];
              end
            end
            smat_pkg::ACT_FIND_MAC,
            smat_pkg::ACT_FIND_NAME,
            smat_pkg::ACT_READ_IDX: begin
              if (p_vld[0]) begin
                oidx_nxt  = p_idx[0];
                omac_nxt  = p_key[0];
                oname_nxt = p_name[0];
              end else begin
                ost_nxt = smat_pkg::ST_NOTFOUND;
              end
            end
            smat_pkg::ACT_REM_IDX,
            smat_pkg::ACT_REM_MAC,
            smat_pkg::ACT_REM_NAME: begin
              if (p_vld[0]) begin
                do_rem    = 1'b1;
                count_nxt = count_r - CW'(1);
                oidx_nxt  = p_idx[0];
              end else begin
                ost_nxt = smat_pkg::ST_NOTFOUND;
              end
            end
            default: begin
              ost_nxt = smat_pkg::ST_NOTFOUND;
            end
          endcase
          ocnt_nxt = count_nxt;
        end
      end
      default: begin
        state_nxt = smat_pkg::S_IDLE;
      end
    endcase
  end

  // Broadcast control to the cells
  always_comb begin
    ctl.match = (state_r == smat_pkg::S_MATCH);
    ctl.scan  = (state_r == smat_pkg::S_SCAN);
    ctl.ins   = do_ins;
    ctl.rem   = do_rem;
    ctl.op    = op_r;
  end

  // Chain tie-off above the top cell
  assign p_vld[ENTRIES]  = 1'b0;
  assign p_idx[ENTRIES]  = '0;
  assign p_key[ENTRIES]  = '0;
  assign p_name[ENTRIES] = '0;
  assign p_dup[ENTRIES]  = 1'b0;

  // Row of cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [smat_pkg::MAC_W-1:0]  pk, nk;
    logic [smat_pkg::NAME_W-1:0] pn, nn;
    logic                        pg;

    if (i == 0) begin : g_lo
      assign pk = '0;
      assign pn = '0;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pk = cell_key[i-1];
      assign pn = cell_name[i-1];
      assign pg = cell_gt[i-1];
    end

    if (i == ENTRIES - 1) begin : g_hi
      assign nk = '0;
      assign nn = '0;
    end else begin : g_nx
      assign nk = cell_key[i+1];
      assign nn = cell_name[i+1];
    end

    smat_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .pos       (p_idx[0]),
      .q_key     (mac_r),
      .q_name    (name_r),
      .q_idx     (idx_r),
      .prev_key  (pk),
      .prev_name (pn),
      .prev_gt   (pg),
      .next_key  (nk),
      .next_name (nn),
      .key_o     (cell_key[i]),
      .name_o    (cell_name[i]),
      .gt_o      (cell_gt[i]),
      .pin_vld   (p_vld[i+1]),
      .pin_idx   (p_idx[i+1]),
      .pin_key   (p_key[i+1]),
      .pin_name  (p_name[i+1]),
      .pin_dup   (p_dup[i+1]),
      .pout_vld  (p_vld[i]),
      .pout_idx  (p_idx[i]),
      .pout_key  (p_key[i]),
      .pout_name (p_name[i]),
      .pout_dup  (p_dup[i])
    );
  end

  assign out_valid       = ovld_r;
  assign out_status      = ost_r;
  assign out_found_index = oidx_r;
  assign out_mac_out     = omac_r;
  assign out_name_out    = oname_r;
  assign out_entry_count = ocnt_r;

endmodule

[design/smat_checker.sv]
// Port-level checks for the sorted MAC alias table, bound to the top level.
module smat_checker #(
  parameter  int ENTRIES = 16,
  localparam int IW      = $clog2(ENTRIES),
  localparam int CW      = $clog2(ENTRIES + 1)
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  out_status,
  input logic [IW-1:0]               out_found_index,
  input logic [smat_pkg::MAC_W-1:0]  out_mac_out,
  input logic [smat_pkg::NAME_W-1:0] out_name_out,
  input logic [CW-1:0]               out_entry_count
);

  // Count never exceeds table size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CW'(ENTRIES))
    else $error("entry count above table size");

  // Failed requests report no position and no entry data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != smat_pkg::ST_OK |->
      out_found_index == '0 && out_mac_out == '0 && out_name_out == '0)
    else $error("failed request carries data");

  // One request in flight: an accepted request closes the input side
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_found_index) && $stable(out_entry_count))
    else $error("stalled result changed");

endmodule

bind sorted_mac_alias_table smat_checker #(.ENTRIES(ENTRIES)) u_smat_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_found_index (out_found_index),
  .out_mac_out     (out_mac_out),
  .out_name_out    (out_name_out),
  .out_entry_count (out_entry_count)
);
